// ===== design/hbc_pkg.sv =====
// hbc_pkg: shared types, constants and helpers for the Hamming block codec.
// Depends on nothing; used by every module of the codec.
`timescale 1ns / 1ps
package hbc_pkg;
	localparam int MaxBytesDef = 32;
	localparam int CntW = 6;

	localparam logic [1:0] ST_CLEAN = 2'd0;
	localparam logic [1:0] ST_FIX   = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [CntW-1:0] n;
		logic            mode;
		logic            ov;
	} hbc_desc_t;

	typedef struct packed {
		logic            bank;
		logic [CntW-1:0] addr;
	} hbc_rd_t;

	// least c >= 1 with 2^c >= bits + c + 1, capped at 16
	function automatic logic [4:0] parity_count(input logic [15:0] bits);
		logic [4:0] c;
		c = 5'd16;
		for (int k = 15; k >= 1; k--) begin
			if ((32'd1 << k) >= 32'(bits) + 32'(k) + 32'd1) c = 5'(k);
		end
		return c;
	endfunction
endpackage

// ===== design/hbc_front.sv =====
// hbc_front: takes input bytes, fills one of two block banks, emits block descriptors.
// Depends on hbc_pkg.
`timescale 1ns / 1ps
module hbc_front #(
	parameter int MAX_BYTES = hbc_pkg::MaxBytesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              mode,
	input  logic [7:0]        data_byte,
	input  logic              last,
	input  logic              q_full,
	output logic              q_push,
	output hbc_pkg::hbc_desc_t q_desc,
	input  hbc_pkg::hbc_rd_t  rd,
	output logic [7:0]        rd_data
);
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	logic [7:0] mem [2][MAX_BYTES];
	logic [hbc_pkg::CntW-1:0] cnt_q;
	logic bm_q, ovf_q, wbank_q;
	logic accept, room, wr_en;

	assign accept = push & ~q_full;
	assign room   = cnt_q < hbc_pkg::CntW'(MAX_BYTES);
	assign wr_en  = accept & room;
	assign q_push = accept & last;

	always_comb begin
		q_desc.n    = room ? cnt_q + 1'b1 : cnt_q;
		q_desc.mode = (cnt_q == '0) ? mode : bm_q;
		q_desc.ov   = ovf_q | ~room;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wbank_q][cnt_q[AW-1:0]] <= data_byte;
		rd_data <= mem[rd.bank][rd.addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			bm_q    <= 1'b0;
			ovf_q   <= 1'b0;
			wbank_q <= 1'b0;
		end else if (accept) begin
			if (cnt_q == '0) bm_q <= mode;
			if (last) begin
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
				wbank_q <= ~wbank_q;
			end else if (room) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end
endmodule

// ===== design/hbc_fifo.sv =====
// hbc_fifo: two-entry descriptor queue between front and back.
// Depends on hbc_pkg.
`timescale 1ns / 1ps
module hbc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hbc_pkg::hbc_desc_t din,
	input  logic               pop,
	output hbc_pkg::hbc_desc_t dout,
	output logic               full,
	output logic               empty
);
	hbc_pkg::hbc_desc_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) ent_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ===== design/hbc_back.sv =====
// hbc_back: bit-serial encode/decode engine and result register.
// Depends on hbc_pkg; reads block banks held in hbc_front.
`timescale 1ns / 1ps
module hbc_back #(
	parameter int MAX_BYTES = hbc_pkg::MaxBytesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  hbc_pkg::hbc_desc_t q_desc,
	output logic               q_pop,
	output logic               busy,
	output hbc_pkg::hbc_rd_t   rd,
	input  logic [7:0]         rd_data,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic [1:0]         status
);
	localparam int BW = $clog2(8 * MAX_BYTES + 17);
	localparam int OW = $clog2(MAX_BYTES + 3);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_RUN   = 6'b000100,
		S_LOAD  = 6'b001000,
		S_LATCH = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [hbc_pkg::CntW-1:0] n_q, rp_q;
	logic mode_q, special_q, pass_q, bank_q;
	logic [4:0] c_q;
	logic [BW-1:0] i_q, acc_q;
	logic [7:0] sh_q, ob_q;
	logic [3:0] shc_q;
	logic [2:0] obc_q;
	logic [OW-1:0] oidx_q;
	logic [1:0] stat_q;
	logic oval_q, olast_q;
	logic [7:0] obyte_q;
	logic [1:0] ostat_q;

	logic [BW-1:0] nbits, total, nb8, limit, ip1;
	logic [OW-1:0] nout;
	logic ispar, need, obit, emit_ok, fin;

	assign nbits = BW'({n_q, 3'b000});
	assign total = nbits + BW'(c_q);
	assign nb8   = (total + BW'(7)) & ~BW'(7);
	assign limit = mode_q ? nbits : nb8;
	assign ip1   = i_q + 1'b1;
	assign ispar = (ip1 & i_q) == '0;
	assign need  = mode_q ? (i_q < nbits) : (!ispar && i_q < total);
	assign nout  = special_q ? OW'(1) : (mode_q ? OW'(n_q) - 1'b1 : OW'(nb8 >> 3));
	assign fin   = oidx_q == nout - 1'b1;
	assign emit_ok = !oval_q || pop;

	always_comb begin
		if (mode_q)
			obit = need & (sh_q[7] ^ (stat_q == hbc_pkg::ST_FIX && ip1 == acc_q));
		else
			obit = ispar ? |(acc_q & ip1) : (need & sh_q[7]);
	end

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign busy     = state_q != S_IDLE;
	assign rd       = '{bank: bank_q, addr: rp_q};
	assign empty    = !oval_q;
	assign out_byte = obyte_q;
	assign out_last = olast_q;
	assign status   = ostat_q;

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_ok) begin
			obyte_q <= ob_q;
			olast_q <= fin;
			ostat_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			mode_q    <= 1'b0;
			special_q <= 1'b0;
			pass_q    <= 1'b0;
			bank_q    <= 1'b0;
			c_q       <= '0;
			i_q       <= '0;
			acc_q     <= '0;
			sh_q      <= '0;
			shc_q     <= '0;
			rp_q      <= '0;
			ob_q      <= '0;
			obc_q     <= '0;
			oidx_q    <= '0;
			stat_q    <= hbc_pkg::ST_CLEAN;
			oval_q    <= 1'b0;
		end else begin
			if (pop && oval_q) oval_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						n_q    <= q_desc.n;
						mode_q <= q_desc.mode;
						oidx_q <= '0;
						obc_q  <= '0;
						ob_q   <= '0;
						if (q_desc.ov) begin
							special_q <= 1'b1;
							stat_q    <= hbc_pkg::ST_LONG;
							state_q   <= S_EMIT;
						end else if (q_desc.mode && q_desc.n <= hbc_pkg::CntW'(1)) begin
							special_q <= 1'b1;
							stat_q    <= hbc_pkg::ST_EMPTY;
							state_q   <= S_EMIT;
						end else begin
							special_q <= 1'b0;
							stat_q    <= hbc_pkg::ST_CLEAN;
							state_q   <= S_PREP;
						end
					end
				end
				S_PREP: begin
					c_q     <= hbc_pkg::parity_count(16'(nbits));
					pass_q  <= 1'b0;
					i_q     <= '0;
					acc_q   <= '0;
					shc_q   <= '0;
					rp_q    <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (!pass_q) begin
						if (i_q == limit) begin
							pass_q <= 1'b1;
							i_q    <= '0;
							rp_q   <= '0;
							shc_q  <= '0;
							if (mode_q && acc_q != '0 && acc_q <= nbits) stat_q <= hbc_pkg::ST_FIX;
						end else if (need && shc_q == '0) begin
							state_q <= S_LOAD;
						end else begin
							if (need) begin
								if (sh_q[7]) acc_q <= acc_q ^ ip1;
								sh_q  <= sh_q << 1;
								shc_q <= shc_q - 1'b1;
							end
							i_q <= ip1;
						end
					end else if (need && shc_q == '0) begin
						state_q <= S_LOAD;
					end else begin
						if (need) begin
							sh_q  <= sh_q << 1;
							shc_q <= shc_q - 1'b1;
						end
						if (need || !mode_q) i_q <= ip1;
						// decode skips parity positions inside the block
						if (!(mode_q && need && ispar)) begin
							ob_q  <= {ob_q[6:0], obit};
							obc_q <= obc_q + 1'b1;
							if (obc_q == 3'd7) state_q <= S_EMIT;
						end
					end
				end
				S_LOAD: state_q <= S_LATCH;
				S_LATCH: begin
					sh_q    <= rd_data;
					shc_q   <= 4'd8;
					rp_q    <= rp_q + 1'b1;
					state_q <= S_RUN;
				end
				S_EMIT: begin
					if (emit_ok) begin
						oval_q <= 1'b1;
						if (fin) begin
							bank_q  <= ~bank_q;
							state_q <= S_IDLE;
						end else begin
							oidx_q  <= oidx_q + 1'b1;
							state_q <= S_RUN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_shc_range: assert property (@(posedge clk) disable iff (!arst_n) shc_q <= 4'd8)
		else $error("shift count out of range");
	a_emit_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> obc_q == 3'd0)
		else $error("byte emitted with partial bit count");
	a_latch_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LATCH |-> $past(state_q) == S_LOAD)
		else $error("latch without load");
	a_status_pass0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && !pass_q) |-> stat_q == hbc_pkg::ST_CLEAN)
		else $error("status set before syndrome done");
endmodule

// ===== design/hamming_block_codec.sv =====
// hamming_block_codec: top level of the Hamming SEC block codec.
// Depends on hbc_pkg, hbc_front, hbc_fifo, hbc_back.
//
//   channel | handshake          | payload
//   input   | push / full        | mode, data_byte, last
//   result  | pop / empty        | out_byte, out_last, status
//
// Input bytes transfer one per cycle while a block bank is free; two banks
// let one block fill while the previous one is worked.
// Per block the engine walks the code bits twice, one bit per cycle, pausing in
// S_LOAD and S_LATCH for each stored byte fetched and in S_EMIT while a result
// byte waits on a full result register; too-long and empty blocks skip the walks.
// Reset is asynchronous, active low, and clears all control state.
// A stalled result holds the engine at its next byte; input stalls once both banks are taken.
`timescale 1ns / 1ps
module hamming_block_codec #(
	parameter int MAX_BYTES = hbc_pkg::MaxBytesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] status
);
	hbc_pkg::hbc_desc_t fdesc, bdesc;
	hbc_pkg::hbc_rd_t   rd;
	logic q_push, q_pop, q_empty, q_full, busy;
	logic [7:0] rd_data;

	// both banks taken: one block in the engine, one waiting in the queue
	assign full = q_full | (busy & ~q_empty);

	hbc_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.clk, .arst_n, .push, .mode, .data_byte, .last,
		.q_full(full), .q_push, .q_desc(fdesc), .rd, .rd_data
	);

	hbc_fifo u_fifo (
		.clk, .arst_n, .push(q_push), .din(fdesc), .pop(q_pop),
		.dout(bdesc), .full(q_full), .empty(q_empty)
	);

	hbc_back #(.MAX_BYTES(MAX_BYTES)) u_back (
		.clk, .arst_n, .q_empty, .q_desc(bdesc), .q_pop, .busy, .rd, .rd_data,
		.pop, .empty, .out_byte, .out_last, .status
	);
endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for hamming_block_codec (encode/decode of byte blocks).
// Depends on hbc_pkg and the codec RTL; a scoreboard class predicts results per block.
`timescale 1ns / 1ps
module tb_top;
	localparam int MAX_B = hbc_pkg::MaxBytesDef;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic [1:0] st;
	} res_t;

	class codec_scoreboard;
		logic [7:0] held [MAX_B+2];
		int         nheld;
		logic       bmode;
		logic       ovf;
		res_t       pending[$];
		int         errors;
		int         checked;

		function new();
			nheld = 0; bmode = 0; ovf = 0; errors = 0; checked = 0;
		endfunction

		function int pcount(int bits);
			int c;
			c = 1;
			while (c < 16 && (1 << c) < bits + c + 1) c++;
			return c;
		endfunction

		function bit is_par(int p);
			return ((p + 1) & p) == 0;
		endfunction

		function void emit(ref logic [7:0] v [MAX_B+2], input int cnt, input logic [1:0] st);
			res_t r;
			for (int k = 0; k < cnt; k++) begin
				r.b = v[k]; r.lst = (k + 1 == cnt); r.st = st;
				pending = {pending, r};
			end
		endfunction

		function void encode(int n);
			logic [7:0] w [MAX_B+2];
			int c, total, nb, src, p;
			logic s;
			c = pcount(8 * n);
			total = 8 * n + c;
			nb = (total + 7) / 8;
			src = 0;
			foreach (w[i]) w[i] = 8'h00;
			for (int i = 0; i < total; i++) begin
				if (!is_par(i)) begin
					w[i >> 3][7 - (i & 7)] = held[src >> 3][7 - (src & 7)];
					src++;
				end
			end
			for (int k = 0; k < c; k++) begin
				p = (1 << k) - 1;
				if (p < nb * 8) begin
					s = 0;
					for (int j = 1 << k; j < nb * 8; j++)
						if (((j + 1) >> k) & 1) s ^= w[j >> 3][7 - (j & 7)];
					w[p >> 3][7 - (p & 7)] = s;
				end
			end
			emit(w, nb, hbc_pkg::ST_CLEAN);
		endfunction

		function void decode(int n);
			logic [7:0] w [MAX_B+2];
			logic [7:0] r [MAX_B+2];
			int nbits, c, syn, taken, want, p;
			logic [1:0] st;
			logic s;
			foreach (w[i]) begin
				w[i] = 8'h00; r[i] = 8'h00;
			end
			if (n <= 1) begin
				emit(r, 1, hbc_pkg::ST_EMPTY);
				return;
			end
			for (int i = 0; i < n; i++) w[i] = held[i];
			nbits = 8 * n;
			c = pcount(nbits);
			syn = 0;
			st = hbc_pkg::ST_CLEAN;
			for (int k = 0; k < c; k++) begin
				p = (1 << k) - 1;
				if (p < nbits) begin
					s = 0;
					for (int j = 1 << k; j < nbits; j++)
						if (((j + 1) >> k) & 1) s ^= w[j >> 3][7 - (j & 7)];
					if (s != w[p >> 3][7 - (p & 7)]) syn += 1 << k;
				end
			end
			if (syn != 0 && syn - 1 < nbits) begin
				w[(syn - 1) >> 3][7 - ((syn - 1) & 7)] ^= 1'b1;
				st = hbc_pkg::ST_FIX;
			end
			want = 8 * (n - 1);
			taken = 0;
			for (int i = 0; i < nbits && taken < want; i++) begin
				if (!is_par(i)) begin
					r[taken >> 3][7 - (taken & 7)] = w[i >> 3][7 - (i & 7)];
					taken++;
				end
			end
			emit(r, n - 1, st);
		endfunction

		function void note_input(logic m, logic [7:0] b, logic l);
			logic [7:0] z [MAX_B+2];
			int n;
			if (nheld == 0 && !ovf) bmode = m;
			if (nheld < MAX_B) begin
				held[nheld] = b;
				nheld++;
			end else ovf = 1;
			if (!l) return;
			n = nheld;
			nheld = 0;
			if (ovf) begin
				ovf = 0;
				z[0] = 8'h00;
				emit(z, 1, hbc_pkg::ST_LONG);
			end else if (bmode == 1'b0) encode(n);
			else decode(n);
		endfunction

		task check_result(logic [7:0] b, logic l, logic [1:0] st);
			res_t e;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected transfer byte=%h last=%b status=%0d", b, l, st));
				return;
			end
			e = pending.pop_front();
			if (b !== e.b) report($sformatf("out_byte %h, want %h", b, e.b));
			if (l !== e.lst) report($sformatf("out_last %b, want %b", l, e.lst));
			if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
		endtask

		task report(string msg);
			errors++;
			$display("tb_top: mismatch #%0d: %s", errors, msg);
		endtask
	endclass

	logic       clk, arst_n, push, mode, last, pop;
	logic [7:0] data_byte;
	logic       full, empty, out_last;
	logic [7:0] out_byte;
	logic [1:0] status;

	codec_scoreboard sb;
	int  send_idle_pct, recv_stall_pct;
	bit  hold_off;
	int  blocks_sent, bytes_sent;

	hamming_block_codec dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb_top: timeout");
		$display("tb_top: FAIL");
		$finish;
	end

	// result side
	initial begin
		pop = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) sb.check_result(out_byte, out_last, status);
			@(negedge clk);
			pop = !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_byte(logic m, logic [7:0] b, logic l);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		push = 1; mode = m; data_byte = b; last = l;
		do @(posedge clk); while (full);
		sb.note_input(m, b, l);
		bytes_sent++;
		@(negedge clk);
		push = 0;
		mode = 1'($urandom); data_byte = 8'($urandom); last = 1'($urandom);
	endtask

	task automatic send_block(logic m, int n, int flip);
		logic [7:0] bb [64];
		for (int i = 0; i < n; i++) bb[i] = 8'($urandom);
		// decode block: random bytes with at most one flipped bit
		if (m && flip >= 0 && n > 1) begin
			bb[0] = bb[0];
			bb[flip >> 3][7 - (flip & 7)] ^= 1'b1;
		end
		for (int i = 0; i < n; i++)
			send_byte(i == 0 ? m : logic'($urandom), bb[i], i == n - 1);
		blocks_sent++;
	endtask

	task automatic send_codeword(int n, int flip);
		logic [7:0] bb [64];
		codec_scoreboard tmp;
		int nb;
		tmp = new();
		for (int i = 0; i < n; i++) bb[i] = 8'($urandom);
		for (int i = 0; i < n; i++) tmp.note_input(1'b0, bb[i], i == n - 1);
		nb = tmp.pending.size();
		for (int i = 0; i < nb; i++) bb[i] = tmp.pending[i].b;
		if (flip >= 0) bb[(flip % (8 * nb)) >> 3][7 - ((flip % (8 * nb)) & 7)] ^= 1'b1;
		for (int i = 0; i < nb; i++)
			send_byte(i == 0 ? 1'b1 : logic'($urandom), bb[i], i == nb - 1);
		blocks_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		push = 0; mode = 0; data_byte = 0; last = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
		blocks_sent = 0; bytes_sent = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, both modes, empty decode, too long, errors
		send_byte(1'b0, 8'h00, 1'b1);
		send_byte(1'b0, 8'hFF, 1'b1);
		send_byte(1'b1, 8'hA5, 1'b1);
		send_codeword(1, -1);
		send_codeword(2, 0);
		send_codeword(3, 5);
		send_block(1'b0, MAX_B, -1);
		send_block(1'b1, MAX_B + 1, -1);
		drain();

		// random phases with differing idle mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int b = 0; b < 3; b++) begin
				case ($urandom_range(9))
					0, 1, 2: send_block(1'b0, $urandom_range(1, 3), -1);
					3, 4, 5: send_codeword($urandom_range(1, 3), $urandom_range(1) ?
						-1 : int'($urandom_range(60)));
					6, 7: send_block(1'b1, $urandom_range(1, 3), -1);
					default: send_codeword(1, $urandom_range(7));
				endcase
			end
			drain();
		end

		// receiver holds off long while input keeps coming
		send_idle_pct = 0; recv_stall_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (3000) @(posedge clk);
				@(negedge clk);
				hold_off = 0;
			end
			for (int b = 0; b < 3; b++) send_block(1'b0, 2, -1);
		join
		drain();

		$display("tb_top: %0d blocks, %0d bytes sent, %0d results checked",
			blocks_sent, bytes_sent, sb.checked);
		$display("tb_top: encode, decode with errors, empty and too-long blocks covered");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top: PASS");
		else begin
			$display("tb_top: %0d results missing", sb.pending.size());
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
